/* hdl/rdcw_pkg.sv */
`default_nettype none

package rdcw_pkg;

    localparam int unsigned MAX_ELEMENTS = 16384;
    localparam int unsigned VALUE_BITS   = 16;
    localparam int unsigned POS_W        = 15;
    localparam int unsigned VAL_IN_W     = 16;
    localparam int unsigned CNT_W        = 15;
    localparam int unsigned IDX_BITS     = $clog2(MAX_ELEMENTS);

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PICK,
        ST_ELEM,
        ST_CNT
    } state_t;

    typedef struct packed {
        opcode_t             opcode;
        logic [POS_W-1:0]    position;
        logic [VAL_IN_W-1:0] element_value;
        logic [POS_W-1:0]    range_left;
        logic [POS_W-1:0]    range_right;
    } item_t;

    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] count;
        logic             error;
    } result_t;

endpackage

`default_nettype wire

/* hdl/range_distinct_count_window.sv */
// Distinct-value counter over a sliding window [left, right]. A load transaction
// (opcode 0) first walks the current window empty, then writes one element if its
// position lies in 1..16384; it returns nothing. A query transaction (opcode 1)
// moves the window edges one position at a time to the requested range and
// returns the number of distinct values in it; a range with left 0, left above
// right or right above 16384 returns 0 with range_error set and leaves the
// window alone. Each edge move steps through element store read, count table
// read and count write-back; a query moves |dL| + |dR| edges, a load moves as
// many as the window holds. After reset the block clears all 65536 count table
// entries, one entry per cycle, with s_ready low.
// Querying a position that was never loaded gives an undefined count.
`default_nettype none

module range_distinct_count_window
    import rdcw_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_opcode,
    input  wire logic [POS_W-1:0]    s_position,
    input  wire logic [VAL_IN_W-1:0] s_element_value,
    input  wire logic [POS_W-1:0]    s_range_left,
    input  wire logic [POS_W-1:0]    s_range_right,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic      [CNT_W-1:0]    m_distinct_count,
    output logic                     m_range_error
);

    item_t                 item;
    result_t               res;
    logic                  out_free;
    logic                  elem_we;
    logic [IDX_BITS-1:0]   elem_waddr;
    logic [VALUE_BITS-1:0] elem_wdata;
    logic [IDX_BITS-1:0]   elem_raddr;
    logic [VALUE_BITS-1:0] elem_rdata;
    logic                  cnt_we;
    logic [VALUE_BITS-1:0] cnt_waddr;
    logic [CNT_W-1:0]      cnt_wdata;
    logic [VALUE_BITS-1:0] cnt_raddr;
    logic [CNT_W-1:0]      cnt_rdata;
    logic                  m_valid_reg;
    logic [CNT_W-1:0]      m_count_reg;
    logic                  m_error_reg;

    assign item.opcode        = opcode_t'(s_opcode);
    assign item.position      = s_position;
    assign item.element_value = s_element_value;
    assign item.range_left    = s_range_left;
    assign item.range_right   = s_range_right;

    assign out_free = !m_valid_reg || m_ready;

    rdcw_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (s_valid),
        .item       (item),
        .item_ready (s_ready),
        .out_free   (out_free),
        .res        (res),
        .elem_we    (elem_we),
        .elem_waddr (elem_waddr),
        .elem_wdata (elem_wdata),
        .elem_raddr (elem_raddr),
        .elem_rdata (elem_rdata),
        .cnt_we     (cnt_we),
        .cnt_waddr  (cnt_waddr),
        .cnt_wdata  (cnt_wdata),
        .cnt_raddr  (cnt_raddr),
        .cnt_rdata  (cnt_rdata)
    );

    rdcw_ram #(
        .ADDR_BITS (IDX_BITS),
        .DATA_BITS (VALUE_BITS)
    ) u_elem_ram (
        .aclk  (aclk),
        .we    (elem_we),
        .waddr (elem_waddr),
        .wdata (elem_wdata),
        .raddr (elem_raddr),
        .rdata (elem_rdata)
    );

    rdcw_ram #(
        .ADDR_BITS (VALUE_BITS),
        .DATA_BITS (CNT_W)
    ) u_cnt_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid) begin
            m_count_reg <= res.count;
            m_error_reg <= res.error;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_distinct_count = m_count_reg;
    assign m_range_error    = m_error_reg;

endmodule

`default_nettype wire

/* hdl/rdcw_ram.sv */
`default_nettype none

module rdcw_ram #(
    parameter int unsigned ADDR_BITS = 8,
    parameter int unsigned DATA_BITS = 8
) (
    input  wire logic                 aclk,
    input  wire logic                 we,
    input  wire logic [ADDR_BITS-1:0] waddr,
    input  wire logic [DATA_BITS-1:0] wdata,
    input  wire logic [ADDR_BITS-1:0] raddr,
    output logic      [DATA_BITS-1:0] rdata
);

    logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* hdl/rdcw_ctrl.sv */
`default_nettype none

module rdcw_ctrl
    import rdcw_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  item_valid,
    input  wire item_t                 item,
    output logic                       item_ready,
    input  wire logic                  out_free,
    output result_t                    res,
    output logic                       elem_we,
    output logic      [IDX_BITS-1:0]   elem_waddr,
    output logic      [VALUE_BITS-1:0] elem_wdata,
    output logic      [IDX_BITS-1:0]   elem_raddr,
    input  wire logic [VALUE_BITS-1:0] elem_rdata,
    output logic                       cnt_we,
    output logic      [VALUE_BITS-1:0] cnt_waddr,
    output logic      [CNT_W-1:0]      cnt_wdata,
    output logic      [VALUE_BITS-1:0] cnt_raddr,
    input  wire logic [CNT_W-1:0]      cnt_rdata
);

    function automatic logic [IDX_BITS-1:0] pos_to_idx(input logic [POS_W-1:0] p);
        logic [POS_W-1:0] pm;
        pm = p - POS_W'(1);
        return IDX_BITS'(pm);
    endfunction

    state_t                state_reg, state_next;
    opcode_t               op_reg, op_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [POS_W-1:0]      ql_reg, ql_next;
    logic [POS_W-1:0]      qr_reg, qr_next;
    logic                  err_reg, err_next;
    logic [POS_W-1:0]      wl_reg, wl_next;
    logic [POS_W-1:0]      wr_reg, wr_next;
    logic [CNT_W-1:0]      distinct_reg, distinct_next;
    logic [VALUE_BITS-1:0] clr_reg, clr_next;
    logic                  enter_reg, enter_next;
    logic [VALUE_BITS-1:0] caddr_reg, caddr_next;
    logic [POS_W-1:0]      step_pos;
    logic                  pos_ok;

    assign pos_ok = (pos_reg != '0) && (32'(pos_reg) <= MAX_ELEMENTS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            wl_reg       <= POS_W'(1);
            wr_reg       <= '0;
            distinct_reg <= '0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            wl_reg       <= wl_next;
            wr_reg       <= wr_next;
            distinct_reg <= distinct_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        pos_reg   <= pos_next;
        val_reg   <= val_next;
        ql_reg    <= ql_next;
        qr_reg    <= qr_next;
        err_reg   <= err_next;
        enter_reg <= enter_next;
        caddr_reg <= caddr_next;
    end

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        pos_next      = pos_reg;
        val_next      = val_reg;
        ql_next       = ql_reg;
        qr_next       = qr_reg;
        err_next      = err_reg;
        wl_next       = wl_reg;
        wr_next       = wr_reg;
        distinct_next = distinct_reg;
        clr_next      = clr_reg;
        enter_next    = enter_reg;
        caddr_next    = caddr_reg;
        step_pos      = wl_reg;
        item_ready    = 1'b0;
        res           = '0;
        elem_we       = 1'b0;
        elem_waddr    = pos_to_idx(pos_reg);
        elem_wdata    = val_reg;
        cnt_we        = 1'b0;
        cnt_waddr     = caddr_reg;
        cnt_wdata     = '0;
        cnt_raddr     = caddr_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                cnt_we    = 1'b1;
                cnt_waddr = clr_reg;
                clr_next  = clr_reg + VALUE_BITS'(1);
                if (clr_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                item_ready = 1'b1;
                if (item_valid) begin
                    op_next    = item.opcode;
                    pos_next   = item.position;
                    val_next   = VALUE_BITS'(item.element_value);
                    ql_next    = item.range_left;
                    qr_next    = item.range_right;
                    err_next   = (item.range_left == '0)
                              || (item.range_left > item.range_right)
                              || (32'(item.range_right) > MAX_ELEMENTS);
                    state_next = ST_PICK;
                end
            end
            ST_PICK: begin
                if (op_reg == OP_QUERY) begin
                    priority if (err_reg) begin
                        if (out_free) begin
                            res        = '{valid: 1'b1, count: '0, error: 1'b1};
                            state_next = ST_IDLE;
                        end
                    end else if (wl_reg > ql_reg) begin
                        step_pos   = wl_reg - POS_W'(1);
                        wl_next    = step_pos;
                        enter_next = 1'b1;
                        state_next = ST_ELEM;
                    end else if (wr_reg < qr_reg) begin
                        step_pos   = wr_reg + POS_W'(1);
                        wr_next    = step_pos;
                        enter_next = 1'b1;
                        state_next = ST_ELEM;
                    end else if (wl_reg < ql_reg) begin
                        step_pos   = wl_reg;
                        wl_next    = wl_reg + POS_W'(1);
                        enter_next = 1'b0;
                        state_next = ST_ELEM;
                    end else if (wr_reg > qr_reg) begin
                        step_pos   = wr_reg;
                        wr_next    = wr_reg - POS_W'(1);
                        enter_next = 1'b0;
                        state_next = ST_ELEM;
                    end else begin
                        if (out_free) begin
                            res = '{valid: 1'b1, count: distinct_reg, error: 1'b0};
                            state_next = ST_IDLE;
                        end
                    end
                end else begin
                    // drain the window before the write
                    if (wl_reg <= wr_reg) begin
                        step_pos   = wl_reg;
                        wl_next    = wl_reg + POS_W'(1);
                        enter_next = 1'b0;
                        state_next = ST_ELEM;
                    end else begin
                        elem_we       = pos_ok;
                        wl_next       = POS_W'(1);
                        wr_next       = '0;
                        distinct_next = '0;
                        state_next    = ST_IDLE;
                    end
                end
            end
            ST_ELEM: begin
                cnt_raddr  = elem_rdata;
                caddr_next = elem_rdata;
                state_next = ST_CNT;
            end
            ST_CNT: begin
                cnt_we = 1'b1;
                if (enter_reg) begin
                    cnt_wdata = cnt_rdata + CNT_W'(1);
                    if (cnt_rdata == '0) begin
                        distinct_next = distinct_reg + CNT_W'(1);
                    end
                end else begin
                    cnt_wdata = cnt_rdata - CNT_W'(1);
                    if (cnt_rdata == CNT_W'(1)) begin
                        distinct_next = distinct_reg - CNT_W'(1);
                    end
                end
                state_next = ST_PICK;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign elem_raddr = pos_to_idx(step_pos);

endmodule

`default_nettype wire

/* hdl/rdcw_checker.sv */
`default_nettype none

module rdcw_checker
    import rdcw_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire logic                s_opcode,
    input wire logic [POS_W-1:0]    s_position,
    input wire logic [VAL_IN_W-1:0] s_element_value,
    input wire logic [POS_W-1:0]    s_range_left,
    input wire logic [POS_W-1:0]    s_range_right,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire logic [CNT_W-1:0]    m_distinct_count,
    input wire logic                m_range_error
);

    logic unused_ok;
    assign unused_ok = s_opcode ^ (^s_position) ^ (^s_element_value)
                     ^ (^s_range_left) ^ (^s_range_right);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_distinct_count)
                                && $stable(m_range_error))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("channels active right after reset");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transaction taken while one is in progress");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_range_error |-> m_distinct_count == '0)
        else $error("rejected range returned a nonzero count");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> 32'(m_distinct_count) <= MAX_ELEMENTS)
        else $error("count exceeds element capacity");

endmodule

bind range_distinct_count_window rdcw_checker u_rdcw_checker (.*);

`default_nettype wire

/* tb/distinct_count_checker.sv */
`default_nettype none

module distinct_count_checker
    import rdcw_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    input  wire logic                s_ready,
    input  wire logic                s_opcode,
    input  wire logic [POS_W-1:0]    s_position,
    input  wire logic [VAL_IN_W-1:0] s_element_value,
    input  wire logic [POS_W-1:0]    s_range_left,
    input  wire logic [POS_W-1:0]    s_range_right,
    input  wire logic                m_valid,
    input  wire logic                m_ready,
    input  wire logic [CNT_W-1:0]    m_distinct_count,
    input  wire logic                m_range_error,
    output int unsigned              fail_count,
    output int unsigned              pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned VALUE_COUNT = 1 << VALUE_BITS;
    localparam int unsigned REPORT_LIMIT = 10;

    typedef struct {
        logic [CNT_W-1:0] count;
        logic             err;
    } answer_t;

    logic [VALUE_BITS-1:0] element_mem [1:MAX_ELEMENTS];
    logic [CNT_W-1:0]      occurrence [0:VALUE_COUNT-1];
    logic [CNT_W-1:0]      distinct_total;
    int unsigned           win_lo;
    int unsigned           win_hi;
    answer_t               expected_answers [$];

    initial begin
        fail_count = 0;
        pending = 0;
    end

    function automatic void admit_position(int unsigned p);
        logic [VALUE_BITS-1:0] v;
        v = element_mem[p];
        if (occurrence[v] == '0) begin
            distinct_total = distinct_total + 1'b1;
        end
        occurrence[v] = occurrence[v] + 1'b1;
    endfunction

    function automatic void retire_position(int unsigned p);
        logic [VALUE_BITS-1:0] v;
        v = element_mem[p];
        occurrence[v] = occurrence[v] - 1'b1;
        if (occurrence[v] == '0) begin
            distinct_total = distinct_total - 1'b1;
        end
    endfunction

    function automatic void apply_load(int unsigned pos, logic [VAL_IN_W-1:0] val);
        while (win_lo <= win_hi) begin
            retire_position(win_lo);
            win_lo++;
        end
        win_lo = 1;
        win_hi = 0;
        distinct_total = '0;
        if (pos >= 1 && pos <= MAX_ELEMENTS) begin
            element_mem[pos] = val[VALUE_BITS-1:0];
        end
    endfunction

    function automatic answer_t count_range_distinct(int unsigned lo, int unsigned hi);
        answer_t a;
        if (lo == 0 || lo > hi || hi > MAX_ELEMENTS) begin
            a.count = '0;
            a.err = 1'b1;
            return a;
        end
        while (win_lo > lo) begin
            win_lo--;
            admit_position(win_lo);
        end
        while (win_hi < hi) begin
            win_hi++;
            admit_position(win_hi);
        end
        while (win_lo < lo) begin
            retire_position(win_lo);
            win_lo++;
        end
        while (win_hi > hi) begin
            retire_position(win_hi);
            win_hi--;
        end
        a.count = distinct_total;
        a.err = 1'b0;
        return a;
    endfunction

    function automatic void note_failure(string msg);
        if (fail_count < REPORT_LIMIT) begin
            $display("%t: %s", $realtime, msg);
        end
        fail_count++;
    endfunction

    always @(posedge aclk) begin
        answer_t want;
        if (!aresetn) begin
            for (int v = 0; v < VALUE_COUNT; v++) begin
                occurrence[v] = '0;
            end
            distinct_total = '0;
            win_lo = 1;
            win_hi = 0;
            expected_answers.delete();
        end else begin
            if (s_valid && s_ready) begin
                if (opcode_t'(s_opcode) == OP_QUERY) begin
                    expected_answers.push_back(count_range_distinct(s_range_left,
                                                                    s_range_right));
                end else begin
                    apply_load(s_position, s_element_value);
                end
            end
            if (m_valid && m_ready) begin
                if (expected_answers.size() == 0) begin
                    note_failure($sformatf("unexpected transaction: count %0d error %0b",
                                           m_distinct_count, m_range_error));
                end else begin
                    want = expected_answers.pop_front();
                    if (m_distinct_count !== want.count) begin
                        note_failure($sformatf("distinct_count expected %0d actual %0d",
                                               want.count, m_distinct_count));
                    end
                    if (m_range_error !== want.err) begin
                        note_failure($sformatf("range_error expected %0b actual %0b",
                                               want.err, m_range_error));
                    end
                end
            end
        end
        pending <= expected_answers.size();
    end

endmodule

`default_nettype wire

/* tb/range_distinct_count_window_test.sv */
`default_nettype none

module range_distinct_count_window_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rdcw_pkg::*;

    localparam int unsigned WORK_SPAN     = 96;
    localparam int unsigned RANDOM_ITEMS  = 1400;
    localparam int unsigned SETTLE_CYCLES = 700;
    localparam int unsigned POS_TOP       = (1 << POS_W) - 1;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic                s_opcode = OP_LOAD;
    logic [POS_W-1:0]    s_position = '0;
    logic [VAL_IN_W-1:0] s_element_value = '0;
    logic [POS_W-1:0]    s_range_left = '0;
    logic [POS_W-1:0]    s_range_right = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [CNT_W-1:0]    m_distinct_count;
    logic                m_range_error;

    int unsigned fail_count;
    int unsigned pending;

    bit          written [1:MAX_ELEMENTS];
    int unsigned filled = 0;
    int unsigned last_lo = 0;
    int unsigned last_hi = 0;
    bit          steady_send = 1'b0;
    int unsigned stall_left = 0;
    int unsigned cycle_count = 0;

    always #5 aclk = ~aclk;

    range_distinct_count_window DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_position       (s_position),
        .s_element_value  (s_element_value),
        .s_range_left     (s_range_left),
        .s_range_right    (s_range_right),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_distinct_count (m_distinct_count),
        .m_range_error    (m_range_error)
    );

    distinct_count_checker checker_i (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_position       (s_position),
        .s_element_value  (s_element_value),
        .s_range_left     (s_range_left),
        .s_range_right    (s_range_right),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_distinct_count (m_distinct_count),
        .m_range_error    (m_range_error),
        .fail_count       (fail_count),
        .pending          (pending)
    );

    function automatic int unsigned pick_gap(bit allow_zero);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (allow_zero && r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if ((cycle_count / 3000) % 4 != 0 && $urandom_range(0, 99) < 15) begin
                stall_left <= pick_gap(1'b0);
            end
        end
    end

    task automatic send_item(input opcode_t op, input int unsigned pos, input int unsigned val,
                             input int unsigned lo, input int unsigned hi);
        int unsigned gap;
        gap = steady_send ? 0 : pick_gap(1'b1);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_position <= pos[POS_W-1:0];
        s_element_value <= val[VAL_IN_W-1:0];
        s_range_left <= lo[POS_W-1:0];
        s_range_right <= hi[POS_W-1:0];
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic load_element(input int unsigned pos, input int unsigned val);
        send_item(OP_LOAD, pos, val, $urandom_range(0, POS_TOP), $urandom_range(0, POS_TOP));
        if (pos >= 1 && pos <= MAX_ELEMENTS) begin
            written[pos] = 1'b1;
        end
        while (filled < MAX_ELEMENTS && written[filled + 1]) begin
            filled++;
        end
    endtask

    task automatic query_range(input int unsigned lo, input int unsigned hi);
        send_item(OP_QUERY, $urandom_range(0, POS_TOP), $urandom_range(0, 65535), lo, hi);
        if (lo != 0 && lo <= hi && hi <= MAX_ELEMENTS) begin
            last_lo = lo;
            last_hi = hi;
        end
    endtask

    task automatic wait_for_answers();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    initial begin
        int unsigned pick;
        int unsigned sel;
        int unsigned span;
        int unsigned lo;
        int unsigned hi;
        int unsigned pos;
        int unsigned val;
        int unsigned tmp;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        load_element(1, 0);
        load_element(2, 65535);
        load_element(3, 0);
        load_element(4, 16'h5555);
        load_element(5, 16'haaaa);
        load_element(6, 65535);
        load_element(7, 16'h8000);
        load_element(8, 1);
        query_range(1, 1);
        query_range(1, 8);
        query_range(2, 2);
        query_range(3, 6);
        query_range(8, 8);
        query_range(1, 8);
        query_range(0, 5);
        query_range(0, 0);
        query_range(5, 4);
        query_range(1, MAX_ELEMENTS + 1);
        query_range(POS_TOP, POS_TOP);
        query_range(MAX_ELEMENTS, MAX_ELEMENTS - 1);
        load_element(0, 123);
        load_element(POS_TOP, 65535);
        load_element(MAX_ELEMENTS, 16'h7fff);
        query_range(1, 8);
        load_element(3, 65535);
        query_range(1, 8);
        wait_for_answers();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady_send = ((n / 100) % 4) == 1;
            if (n % 300 == 299) begin
                wait_for_answers();
            end
            pick = $urandom_range(0, 99);
            span = (filled < WORK_SPAN) ? filled : WORK_SPAN;
            if (pick < 45 || span == 0) begin
                sel = $urandom_range(0, 99);
                if (sel < 35 && filled < WORK_SPAN) begin
                    pos = filled + 1;
                end else if (sel < 85) begin
                    pos = $urandom_range(1, WORK_SPAN);
                end else if (sel < 93) begin
                    pos = $urandom_range(1, MAX_ELEMENTS);
                end else if (sel < 96) begin
                    pos = 0;
                end else begin
                    pos = $urandom_range(MAX_ELEMENTS + 1, POS_TOP);
                end
                sel = $urandom_range(0, 9);
                if (sel < 6) begin
                    val = $urandom_range(0, 15);
                end else if (sel < 8) begin
                    val = $urandom_range(0, 255);
                end else begin
                    val = $urandom_range(0, 65535);
                end
                load_element(pos, val);
            end else if (pick < 90) begin
                if ($urandom_range(0, 9) < 6 && last_hi != 0) begin
                    lo = last_lo + $urandom_range(0, 8);
                    lo = (lo > 4) ? lo - 4 : 1;
                    hi = last_hi + $urandom_range(0, 8);
                    hi = (hi > 4) ? hi - 4 : 1;
                    if (lo > span) lo = span;
                    if (hi > span) hi = span;
                    if (lo > hi) begin
                        tmp = lo;
                        lo = hi;
                        hi = tmp;
                    end
                end else begin
                    hi = $urandom_range(1, span);
                    lo = $urandom_range(1, hi);
                end
                query_range(lo, hi);
            end else begin
                case ($urandom_range(0, 2))
                    0: begin
                        lo = 0;
                        hi = $urandom_range(0, POS_TOP);
                    end
                    1: begin
                        hi = $urandom_range(0, POS_TOP - 1);
                        lo = $urandom_range(hi + 1, POS_TOP);
                    end
                    default: begin
                        hi = $urandom_range(MAX_ELEMENTS + 1, POS_TOP);
                        lo = $urandom_range(0, POS_TOP);
                    end
                endcase
                query_range(lo, hi);
            end
        end

        wait_for_answers();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("range_distinct_count_window: match");
        end else begin
            $display("range_distinct_count_window: mismatch");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("range_distinct_count_window: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

/* range_distinct_count_window.f */
hdl/rdcw_pkg.sv
hdl/rdcw_ram.sv
hdl/rdcw_ctrl.sv
hdl/range_distinct_count_window.sv
hdl/rdcw_checker.sv
tb/distinct_count_checker.sv
tb/range_distinct_count_window_test.sv
